@@ src/vwma_pkg.sv @@
`timescale 1ns / 1ps

package vwma_pkg;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ADDR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_WIDTH + ADDR_W;
  localparam int SHIFT_K = SUM_W + LEN_W;
  localparam int RECIP_W = SHIFT_K + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [SUM_W-1:0]               mag_t;
  typedef logic [LEN_W-1:0]               len_t;
  typedef logic [ADDR_W-1:0]              addr_t;
  typedef logic [RECIP_W-1:0]             recip_t;
  typedef logic [PROD_W-1:0]              prod_t;
  typedef recip_t                         recip_tab_t [MAX_WINDOW+1];

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV,
    S_SWEEP
  } state_t;

  // ceil(2^K / n): exact floor division for any magnitude below 2^SUM_W
  function automatic recip_tab_t recip_table();
    recip_tab_t         tab;
    longint unsigned    num;
    longint unsigned    dvd;
    longint unsigned    rem;
    longint unsigned    q;
    num = longint'(1) << SHIFT_K;
    tab[0] = '0;
    for (int i = 1; i <= MAX_WINDOW; i++) begin
      dvd = num + longint'(i) - 1;
      rem = 0;
      q   = 0;
      for (int b = 63; b >= 0; b--) begin
        rem = (rem << 1) | ((dvd >> b) & 1);
        q   = q << 1;
        if (rem >= longint'(i)) begin
          rem = rem - longint'(i);
          q   = q | 1;
        end
      end
      tab[i] = RECIP_W'(q);
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = recip_table();

endpackage

@@ src/vwma_if.sv @@
`timescale 1ns / 1ps

interface vwma_sample_if import vwma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface vwma_average_if import vwma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface vwma_cfg_if import vwma_pkg::*; ();
  logic valid;
  logic ready;
  len_t window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

@@ src/vwma_div.sv @@
`timescale 1ns / 1ps

module vwma_div import vwma_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sum_t    sum,
  input  len_t    len,
  input  logic    take,
  output logic    done,
  output sample_t quotient
);

  logic  busy;
  logic  neg;
  prod_t prod;
  mag_t  mag;
  sample_t q_mag;

  assign mag   = sum[SUM_W-1] ? mag_t'(-sum) : mag_t'(sum);
  assign q_mag = sample_t'(prod[SHIFT_K +: SAMPLE_WIDTH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      if (busy) begin
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(mag) * PROD_W'(RECIP_TAB[len]);
      neg  <= sum[SUM_W-1];
    end
    if (busy) begin
      quotient <= neg ? -q_mag : q_mag;
    end
  end

endmodule

@@ src/variable_window_moving_average.sv @@
`timescale 1ns / 1ps
// channel   dir  payload              word moves when
// samples   in   sample[15:0] s       valid && ready
// averages  out  average[15:0] s      valid && ready
// cfg       in   window_length[5:0]   valid && ready
//
// Per word: read old entry, update running sum and store, reciprocal
// multiply, negate, load output register once free, then the next word.
// A length write re-sums the new window from the store and reduces the
// position by repeated subtraction.
// Reset clears length to 32, position and sum to zero, store valid bits.
// The output register holds a result while the next word is accepted.

module variable_window_moving_average import vwma_pkg::*; (
  input  logic clk,
  input  logic rst,
  vwma_sample_if.sink    samples,
  vwma_average_if.source averages,
  vwma_cfg_if.sink       cfg
);

  state_t  state;
  state_t  state_next;

  len_t    len;
  addr_t   pos;
  sum_t    sum;
  sample_t sample_hold;
  addr_t   slot;
  len_t    sweep_idx;
  logic    rd_pend;

  sample_t mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld;
  sample_t rd_data;
  logic    rd_vld;
  addr_t   rd_addr;
  sample_t old;

  len_t    base;
  addr_t   slot_now;
  len_t    pos_inc;
  logic    cfg_ok;
  logic    cfg_take;
  logic    sample_take;
  logic    sweep_issue;

  logic    div_start;
  logic    div_done;
  logic    div_take;
  sample_t div_q;

  logic    out_valid;
  sample_t out_avg;

  assign base        = len_t'(MAX_WINDOW) - len;
  assign slot_now    = addr_t'(base + len_t'(pos));
  assign pos_inc     = len_t'(pos) + len_t'(1);
  assign cfg_ok      = (cfg.window_length != '0) &&
                       (cfg.window_length <= len_t'(MAX_WINDOW));
  assign cfg_take    = cfg.valid && cfg.ready;
  assign sample_take = samples.valid && samples.ready;
  assign sweep_issue = (state == S_SWEEP) && (sweep_idx != len_t'(MAX_WINDOW));
  assign rd_addr     = (state == S_SWEEP) ? sweep_idx[ADDR_W-1:0] : slot_now;
  assign old         = rd_vld ? rd_data : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cfg_take && cfg_ok) begin
          state_next = S_SWEEP;
        end else if (sample_take) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_START;
      S_START:  state_next = S_DIV;
      S_DIV: begin
        if (div_take) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (!sweep_issue && !rd_pend && (len_t'(pos) < len)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cfg.ready     = 1'b0;
    samples.ready = 1'b0;
    div_start     = 1'b0;
    div_take      = 1'b0;
    case (state)
      S_IDLE: begin
        cfg.ready     = 1'b1;
        samples.ready = !cfg.valid;
      end
      S_START: div_start = 1'b1;
      S_DIV:   div_take  = div_done && (!out_valid || averages.ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= len_t'(MAX_WINDOW);
      pos     <= '0;
      sum     <= '0;
      vld     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= sweep_issue;
      case (state)
        S_IDLE: begin
          if (cfg_take && cfg_ok) begin
            len       <= cfg.window_length;
            sweep_idx <= len_t'(MAX_WINDOW) - cfg.window_length;
            sum       <= '0;
          end
        end
        S_UPDATE: begin
          sum       <= sum - sum_t'(old) + sum_t'(sample_hold);
          vld[slot] <= 1'b1;
          pos       <= (pos_inc == len) ? '0 : addr_t'(pos_inc);
        end
        S_SWEEP: begin
          if (sweep_issue) begin
            sweep_idx <= sweep_idx + len_t'(1);
          end
          if (rd_pend) begin
            sum <= sum + sum_t'(old);
          end
          if (len_t'(pos) >= len) begin
            pos <= addr_t'(len_t'(pos) - len);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      sample_hold <= samples.sample;
      slot        <= slot_now;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      mem[slot] <= sample_hold;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  vwma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (sum),
    .len      (len),
    .take     (div_take),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_avg <= div_q;
    end
  end

  assign averages.valid   = out_valid;
  assign averages.average = out_avg;

endmodule

@@ tb/tb_variable_window_moving_average.sv @@
`timescale 1ns / 1ps

module tb_variable_window_moving_average import vwma_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CFG_EVERY    = 120;

  logic clk;
  logic rst;

  vwma_sample_if  samples ();
  vwma_average_if averages ();
  vwma_cfg_if     cfg ();

  variable_window_moving_average dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .averages (averages),
    .cfg      (cfg)
  );

  // predictor state
  sample_t window_store [MAX_WINDOW];
  int      window_pos;
  int      window_len;

  sample_t pending_averages [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct;
  int      recv_idle_pct;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic sample_t predict_average(input sample_t s);
    int     base;
    longint total;
    base = MAX_WINDOW - window_len;
    window_store[base + window_pos] = s;
    window_pos = (window_pos + 1) % window_len;
    total = 0;
    for (int i = base; i < MAX_WINDOW; i++) begin
      total += longint'(window_store[i]);
    end
    return sample_t'(total / window_len);
  endfunction

  function automatic void apply_length(input len_t v);
    if (v >= 1 && v <= MAX_WINDOW) begin
      window_len = int'(v);
      window_pos = window_pos % window_len;
    end
  endfunction

  function automatic void flag_mismatch(input string msg);
    if (mismatch_count < 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endfunction

  // receiver side
  always @(posedge clk) begin
    averages.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    sample_t exp_avg;
    if (!rst && averages.valid && averages.ready) begin
      if (pending_averages.size() == 0) begin
        flag_mismatch($sformatf("unexpected word, average %0d", averages.average));
      end else begin
        exp_avg = pending_averages.pop_front();
        if (averages.average !== exp_avg) begin
          flag_mismatch($sformatf("average expected %0d actual %0d",
                                  exp_avg, averages.average));
        end
      end
    end
  end

  task automatic send_sample(input sample_t s);
    cfg.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
      cfg.valid <= 1'b0;
    end
    samples.valid  <= 1'b1;
    samples.sample <= s;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    pending_averages.push_back(predict_average(s));
  endtask

  // only while idle: all averages drained
  task automatic write_length(input len_t v);
    samples.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    cfg.valid         <= 1'b1;
    cfg.window_length <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_length(v);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
      1, 2:    return sample_t'($urandom_range(16) - 8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic len_t random_length();
    case ($urandom_range(5))
      0:       return len_t'(1);
      1:       return len_t'(MAX_WINDOW);
      2:       return $urandom_range(1) ? len_t'(0) : len_t'($urandom_range(63, MAX_WINDOW + 1));
      default: return len_t'($urandom_range(MAX_WINDOW, 1));
    endcase
  endfunction

  // store is zero after reset, so early averages mix in zeros
  task automatic test_first_pass();
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
  endtask

  task automatic test_length_limits();
    write_length(len_t'(1));
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    write_length(len_t'(0));
    write_length(len_t'(MAX_WINDOW + 1));
    write_length(len_t'(63));
    send_sample(16'sh5555);
    write_length(len_t'(MAX_WINDOW));
    send_sample(16'sh8000);
    send_sample(16'sh2aaa);
  endtask

  // negative sums truncate toward zero
  task automatic test_truncation();
    write_length(len_t'(3));
    send_sample(-16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd2);
    write_length(len_t'(7));
    send_sample(-16'sd5);
    send_sample(16'sd3);
  endtask

  // position reduced modulo the new length, store kept
  task automatic test_length_change();
    write_length(len_t'(31));
    send_sample(16'sh1234);
    send_sample(-16'sh1234);
    write_length(len_t'(5));
    send_sample(16'sh7fff);
    write_length(len_t'(2));
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % CFG_EVERY == 0) begin
        write_length(random_length());
      end
      send_sample(random_sample());
    end
  endtask

  initial begin
    rst                 = 1'b1;
    samples.valid       = 1'b0;
    samples.sample      = '0;
    cfg.valid           = 1'b0;
    cfg.window_length   = '0;
    send_idle_pct       = 28;
    recv_idle_pct       = 55;
    window_pos          = 0;
    window_len          = MAX_WINDOW;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      window_store[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_first_pass();
    test_length_limits();
    test_truncation();
    test_length_change();
    test_random_traffic(584, 28, 55);
    test_random_traffic(584, 55, 28);
    test_random_traffic(584, 0, 0);
    write_length(len_t'(MAX_WINDOW));
    send_sample(16'sh7fff);

    samples.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    cfg.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ variable_window_moving_average.f @@
src/vwma_pkg.sv
src/vwma_if.sv
src/vwma_div.sv
src/variable_window_moving_average.sv
tb/tb_variable_window_moving_average.sv
